FILE: rtl/lcdt_pkg.sv
// Shared types, codes and default timing constants of the LCD mode timing controller.
`default_nettype none

package lcdt_pkg;

  // Default timing, in dots and lines.
  localparam int unsigned OAM_DOTS_DEF      = 80;
  localparam int unsigned DRAW_DOTS_DEF     = 172;
  localparam int unsigned HBLANK_DOTS_DEF   = 204;
  localparam int unsigned LINE_DOTS_DEF     = 456;
  localparam int unsigned VISIBLE_LINES_DEF = 144;
  localparam int unsigned FRAME_LINES_DEF   = 154;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Fixed field widths.
  localparam int unsigned DOT_W  = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned BYTE_W = 8;

  // Status register masks: bits written by software, and the phase bits.
  localparam logic [7:0] STATUS_WR_MASK = 8'hF8;
  localparam logic [7:0] PHASE_MASK     = 8'h03;

  // Input mode codes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Register select codes.
  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_STAT = 2'd1;
  localparam logic [1:0] REG_CMP  = 2'd2;
  localparam logic [1:0] REG_LINE = 2'd3;

  // Display phase, as it reads in the status register.
  typedef enum logic [1:0] {
    PH_HBLANK = 2'd0,
    PH_VBLANK = 2'd1,
    PH_OAM    = 2'd2,
    PH_DRAW   = 2'd3
  } phase_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [3:0] {
    OP_TICK,
    OP_WR_CTRL,
    OP_WR_STAT,
    OP_WR_CMP,
    OP_RD_CTRL,
    OP_RD_STAT,
    OP_RD_CMP,
    OP_RD_LINE,
    OP_NOP
  } op_t;

  // One queued command: the operation and its byte argument
  // (dot count for a tick, data byte for a write).
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] arg;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [0:0] {
    S_IDLE,
    S_RUN
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/lcdt_front.sv
// Front end: accepts input transactions and classifies them into queue commands.
`default_nettype none

module lcdt_front
  import lcdt_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [1:0]  reg_sel,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  dots,
  input  wire logic        q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  // Accept whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Decode mode and register select into a single operation code.
  always_comb begin
    q_cmd.op  = OP_NOP;
    q_cmd.arg = write_data;
    case (mode)
      MODE_TICK: begin
        q_cmd.op  = OP_TICK;
        q_cmd.arg = dots;
      end
      MODE_WRITE: begin
        case (reg_sel)
          REG_CTRL: q_cmd.op = OP_WR_CTRL;
          REG_STAT: q_cmd.op = OP_WR_STAT;
          REG_CMP:  q_cmd.op = OP_WR_CMP;
          default:  q_cmd.op = OP_NOP;
        endcase
      end
      MODE_READ: begin
        case (reg_sel)
          REG_CTRL: q_cmd.op = OP_RD_CTRL;
          REG_STAT: q_cmd.op = OP_RD_STAT;
          REG_CMP:  q_cmd.op = OP_RD_CMP;
          default:  q_cmd.op = OP_RD_LINE;
        endcase
      end
      default: q_cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lcdt_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none

module lcdt_queue
  import lcdt_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lcdt_back.sv
// Back end: executes queued commands and steps the dot and line timing one dot a cycle.
`default_nettype none

module lcdt_back
  import lcdt_pkg::*;
#(
  parameter int unsigned OAM_DOTS      = OAM_DOTS_DEF,
  parameter int unsigned DRAW_DOTS     = DRAW_DOTS_DEF,
  parameter int unsigned HBLANK_DOTS   = HBLANK_DOTS_DEF,
  parameter int unsigned LINE_DOTS     = LINE_DOTS_DEF,
  parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int unsigned FRAME_LINES   = FRAME_LINES_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_not_empty,
  input  wire cmd_t       q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            vblank_request,
  output logic            lcd_status_request,
  output logic [7:0]      read_data
);

  localparam logic [DOT_W-1:0]  OAM_END    = DOT_W'(OAM_DOTS);
  localparam logic [DOT_W-1:0]  DRAW_END   = DOT_W'(DRAW_DOTS);
  localparam logic [DOT_W-1:0]  HBLANK_END = DOT_W'(HBLANK_DOTS);
  localparam logic [DOT_W-1:0]  LINE_END   = DOT_W'(LINE_DOTS);
  localparam logic [LINE_W-1:0] VIS_LINE   = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] FRAME_LINE = LINE_W'(FRAME_LINES);

  // Timing and register state.
  back_state_t        state;
  back_state_t        state_next;
  logic [DOT_W-1:0]   dot_count;
  logic [LINE_W-1:0]  line_number;
  phase_t             phase;
  logic [4:0]         stat_sel;     // status bits 7..3
  logic               stat_match;   // status bit 2
  phase_t             stat_phase;   // status bits 1..0
  logic [7:0]         lcd_control;
  logic [7:0]         compare_line;
  logic [BYTE_W-1:0]  remaining;
  logic               acc_vb;
  logic               acc_st;

  // Select bits, split out of the status register.
  logic sel_hblank;
  logic sel_vblank;
  logic sel_oam;
  logic sel_match;
  logic enabled;
  logic [7:0] status_value;
  logic [7:0] stat_wr;

  assign sel_hblank   = stat_sel[0];
  assign sel_vblank   = stat_sel[1];
  assign sel_oam      = stat_sel[2];
  assign sel_match    = stat_sel[3];
  assign enabled      = lcd_control[7];
  assign status_value = {stat_sel, stat_match, stat_phase};
  assign stat_wr      = q_cmd.arg & STATUS_WR_MASK;

  // One-dot step of the timing state.
  logic [DOT_W-1:0]  dot_inc;
  logic [LINE_W-1:0] line_inc;
  logic [DOT_W-1:0]  dot_step;
  logic [LINE_W-1:0] line_step;
  phase_t            phase_step;
  logic              match_step;
  logic              vb_hit;
  logic              st_hit;

  assign dot_inc  = dot_count + DOT_W'(1);
  assign line_inc = line_number + LINE_W'(1);

  always_comb begin
    dot_step   = dot_inc;
    line_step  = line_number;
    phase_step = phase;
    match_step = stat_match;
    vb_hit     = 1'b0;
    st_hit     = 1'b0;
    case (phase)
      PH_OAM: begin
        if (dot_inc >= OAM_END) begin
          dot_step   = '0;
          phase_step = PH_DRAW;
        end
      end
      PH_DRAW: begin
        if (dot_inc >= DRAW_END) begin
          dot_step   = '0;
          phase_step = PH_HBLANK;
          match_step = (compare_line == line_number);
          st_hit     = sel_hblank || (sel_match && (compare_line == line_number));
        end
      end
      PH_HBLANK: begin
        if (dot_inc >= HBLANK_END) begin
          dot_step  = '0;
          line_step = line_inc;
          if (line_inc == VIS_LINE) begin
            phase_step = PH_VBLANK;
            vb_hit     = 1'b1;
            st_hit     = sel_vblank;
          end else begin
            phase_step = PH_OAM;
            st_hit     = sel_oam;
          end
        end
      end
      PH_VBLANK: begin
        if (dot_inc >= LINE_END) begin
          dot_step  = '0;
          line_step = line_inc;
          if (line_inc == FRAME_LINE) begin
            line_step  = '0;
            phase_step = PH_OAM;
            st_hit     = sel_oam;
          end
        end
      end
      default: begin
        dot_step = dot_inc;
      end
    endcase
  end

  // Control outputs of the sequencer.
  logic       slot_free;
  logic       start_run;
  logic       last_dot;
  logic       out_load;
  logic       res_vb;
  logic       res_st;
  logic [7:0] res_rd;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    q_pop     = 1'b0;
    start_run = 1'b0;
    last_dot  = 1'b0;
    out_load  = 1'b0;
    res_vb    = 1'b0;
    res_st    = 1'b0;
    res_rd    = '0;
    case (state)
      S_IDLE: begin
        if (q_not_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_TICK && enabled && q_cmd.arg != '0) begin
            start_run = 1'b1;
          end else begin
            out_load = 1'b1;
            case (q_cmd.op)
              OP_RD_CTRL: res_rd = lcd_control;
              OP_RD_STAT: res_rd = status_value;
              OP_RD_CMP:  res_rd = compare_line;
              OP_RD_LINE: res_rd = line_number;
              default:    res_rd = '0;
            endcase
          end
        end
      end
      S_RUN: begin
        if (remaining == BYTE_W'(1)) begin
          last_dot = 1'b1;
          out_load = 1'b1;
          res_vb   = acc_vb || vb_hit;
          res_st   = acc_st || st_hit;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start_run) state_next = S_RUN;
      S_RUN:   if (last_dot) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dot_count    <= '0;
      line_number  <= '0;
      phase        <= PH_OAM;
      stat_sel     <= '0;
      stat_match   <= 1'b0;
      stat_phase   <= PH_HBLANK;
      lcd_control  <= '0;
      compare_line <= '0;
      remaining    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        case (q_cmd.op)
          OP_WR_CTRL: lcd_control  <= q_cmd.arg;
          OP_WR_STAT: stat_sel     <= stat_wr[7:3];
          OP_WR_CMP:  compare_line <= q_cmd.arg;
          OP_TICK: begin
            // An enabled tick of zero dots still refreshes the phase bits.
            if (enabled && q_cmd.arg == '0) begin
              stat_phase <= phase_t'(PHASE_MASK[1:0] & phase);
            end
          end
          default: begin
            remaining <= remaining;
          end
        endcase
      end
      if (start_run) begin
        remaining <= q_cmd.arg;
      end
      if (state == S_RUN) begin
        remaining   <= remaining - BYTE_W'(1);
        dot_count   <= dot_step;
        line_number <= line_step;
        phase       <= phase_step;
        stat_match  <= match_step;
        if (last_dot) begin
          stat_phase <= phase_t'(PHASE_MASK[1:0] & phase_step);
        end
      end
    end
  end

  // Interrupt accumulators over one tick.
  always_ff @(posedge clk) begin
    if (start_run) begin
      acc_vb <= 1'b0;
      acc_st <= 1'b0;
    end else if (state == S_RUN) begin
      acc_vb <= acc_vb || vb_hit;
      acc_st <= acc_st || st_hit;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      vblank_request     <= res_vb;
      lcd_status_request <= res_st;
      read_data          <= res_rd;
    end
  end

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst) out_load |-> slot_free)
    else $error("result register overwritten while stalled");

  // While dots are being stepped the output slot stays empty.
  assert property (@(posedge clk) disable iff (rst) (state == S_RUN) |-> !out_valid)
    else $error("result pending during a tick run");

  // A started run holds the tick's dot count and never sits at zero.
  assert property (@(posedge clk) disable iff (rst)
    start_run |=> (state == S_RUN) && (remaining == $past(q_cmd.arg)))
    else $error("tick run did not start with its dot count");

  assert property (@(posedge clk) disable iff (rst) (state == S_RUN) |-> (remaining != '0))
    else $error("tick run with no dots left");

endmodule

`default_nettype wire

FILE: rtl/lcd_mode_timing_controller.sv
// Top level of the LCD mode and scanline timing controller.
// Each input transaction yields exactly one result transaction, in order. A front end
// decodes the transaction into a command and pushes it into a QUEUE_DEPTH-entry queue,
// so input is taken while the back end is busy until the queue is full. The back end
// executes one command at a time: a register read or write, a disabled tick or a tick
// of zero dots completes in the idle state, and an enabled tick of N dots steps the
// dot counter in the run state through OAM scan, drawing, horizontal blank and vertical
// blank one dot per cycle. The result waits in an output register until it is taken,
// and the next command is started in the same cycle that it is taken. No clearing pass
// is needed after reset.
`default_nettype none

module lcd_mode_timing_controller
  import lcdt_pkg::*;
#(
  parameter int unsigned OAM_DOTS      = OAM_DOTS_DEF,
  parameter int unsigned DRAW_DOTS     = DRAW_DOTS_DEF,
  parameter int unsigned HBLANK_DOTS   = HBLANK_DOTS_DEF,
  parameter int unsigned LINE_DOTS     = LINE_DOTS_DEF,
  parameter int unsigned VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int unsigned FRAME_LINES   = FRAME_LINES_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [1:0] reg_sel,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] dots,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            vblank_request,
  output logic            lcd_status_request,
  output logic [7:0]      read_data
);

  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_not_empty;
  cmd_t head_cmd;

  lcdt_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .reg_sel    (reg_sel),
    .write_data (write_data),
    .dots       (dots),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  lcdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  lcdt_back #(
    .OAM_DOTS      (OAM_DOTS),
    .DRAW_DOTS     (DRAW_DOTS),
    .HBLANK_DOTS   (HBLANK_DOTS),
    .LINE_DOTS     (LINE_DOTS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .FRAME_LINES   (FRAME_LINES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_not_empty        (q_not_empty),
    .q_cmd              (head_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .vblank_request     (vblank_request),
    .lcd_status_request (lcd_status_request),
    .read_data          (read_data)
  );

endmodule

`default_nettype wire
